[rtl/core/grouped_argument_splitter_core_macros.svh]
// Assertion macros used by the tokenizer checker.
`ifndef GROUPED_ARGUMENT_SPLITTER_CORE_MACROS_SVH
`define GROUPED_ARGUMENT_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define GAS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Next-cycle implication under synchronous reset.
`define GAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

[rtl/core/gas_pkg.sv]
// Types, constants and helper functions of the argument splitter.
package gas_pkg;

   localparam int NUM_QUOTE_SLOTS_DEF = 4;
   localparam int INDEX_WIDTH_DEF     = 16;
   localparam int CSR_INDEX_W         = 3;
   localparam int BYTE_W              = 8;
   localparam int POS_W               = 16;
   localparam int RSP_DEPTH           = 4;

   localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'd0;
   localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_DQUOTE = 8'd34;
   localparam logic [BYTE_W-1:0] CHAR_SQUOTE = 8'd39;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_STRAY_CLOSE = 2'd1,
      ERR_STRAY_OPEN  = 2'd2,
      ERR_LEFT_OPEN   = 2'd3
   } err_type;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  out_byte;
      err_type            error_code;
      logic [POS_W-1:0]   error_position;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [BYTE_W-1:0] quote_reset(int unsigned slot);
      case (slot)
         0: return CHAR_DQUOTE;
         1: return CHAR_SQUOTE;
         default: return CHAR_NUL;
      endcase
   endfunction

   function automatic logic is_ws(logic [BYTE_W-1:0] b);
      return (b == CHAR_SPACE) || (b inside {[CHAR_TAB:CHAR_CR]});
   endfunction

endpackage

[rtl/core/gas_if.sv]
// Request and response channel interfaces of the argument splitter.
interface gas_req_if;
   import gas_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface gas_rsp_if;
   import gas_pkg::*;
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [BYTE_W-1:0] out_byte;
   err_type           error_code;
   logic [POS_W-1:0]  error_position;
   logic              last_of_run;

   modport source (output valid, output kind, output out_byte, output error_code,
                   output error_position, output last_of_run, input ready);
   modport sink   (input valid, input kind, input out_byte, input error_code,
                   input error_position, input last_of_run, output ready);
endinterface

[rtl/core/gas_csr.sv]
// Quote character registers of the argument splitter.
module gas_csr #(
   parameter int NUM_QUOTE_SLOTS = gas_pkg::NUM_QUOTE_SLOTS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_we,
   input  logic [gas_pkg::CSR_INDEX_W-1:0]               csr_index,
   input  logic [gas_pkg::BYTE_W-1:0]                    csr_wdata,
   output logic [NUM_QUOTE_SLOTS-1:0][gas_pkg::BYTE_W-1:0] quote_chars
);
   import gas_pkg::*;

   logic [NUM_QUOTE_SLOTS-1:0][BYTE_W-1:0] quote_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_QUOTE_SLOTS; i++) begin
         if (reset) begin
            quote_ff[i] <= quote_reset(i);
         end else if (csr_we && csr_index == CSR_INDEX_W'(i)) begin
            quote_ff[i] <= csr_wdata;
         end
      end
   end

   assign quote_chars = quote_ff;

endmodule

[rtl/core/gas_step.sv]
// Per-byte tokenizer state and result generation.
module gas_step #(
   parameter int NUM_QUOTE_SLOTS = gas_pkg::NUM_QUOTE_SLOTS_DEF,
   parameter int INDEX_WIDTH     = gas_pkg::INDEX_WIDTH_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            accept,
   input  logic [gas_pkg::BYTE_W-1:0]                      in_byte,
   input  logic                                            end_of_string,
   input  logic [NUM_QUOTE_SLOTS-1:0][gas_pkg::BYTE_W-1:0] quote_chars,
   output gas_pkg::push_type                               push
);
   import gas_pkg::*;

   logic [BYTE_W-1:0]      open_ff, open_in;
   logic                   nonempty_ff, nonempty_in;
   logic                   pending_ff, pending_in;
   logic                   error_ff, error_in;
   logic [INDEX_WIDTH-1:0] index_ff, index_in;

   logic                   ws;
   logic                   quote_hit;
   logic [POS_W-1:0]       pos_cur;
   logic [POS_W-1:0]       pos_prev;
   logic                   main_has, end_has;
   rsp_type                main_rsp, end_rsp;

   function automatic rsp_type make_rsp(kind_type k, logic [BYTE_W-1:0] b, err_type c,
                                        logic [POS_W-1:0] p);
      rsp_type r;
      r.kind           = k;
      r.out_byte       = b;
      r.error_code     = c;
      r.error_position = p;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   function automatic logic [POS_W-1:0] to_pos(logic [INDEX_WIDTH-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[POS_W-1:0];
   endfunction

   always_comb begin
      ws        = is_ws(in_byte);
      quote_hit = 1'b0;
      for (int i = 0; i < NUM_QUOTE_SLOTS; i++) begin
         if (quote_chars[i] == in_byte) begin
            quote_hit = 1'b1;
         end
      end
      if (in_byte == CHAR_NUL || ws) begin
         quote_hit = 1'b0;
      end
      pos_cur  = to_pos(index_ff);
      pos_prev = to_pos(index_ff - INDEX_WIDTH'(1));
   end

   always_comb begin
      open_in     = open_ff;
      nonempty_in = nonempty_ff;
      pending_in  = pending_ff;
      error_in    = error_ff;
      index_in    = index_ff + INDEX_WIDTH'(1);
      main_has    = 1'b0;
      main_rsp    = '0;
      end_has     = 1'b0;
      end_rsp     = '0;

      if (!error_ff) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            main_has   = 1'b1;
            if (ws) begin
               main_rsp = make_rsp(KIND_END, CHAR_NUL, ERR_NONE, '0);
            end else begin
               main_rsp = make_rsp(KIND_ERROR, CHAR_NUL, ERR_STRAY_CLOSE, pos_prev);
               error_in = 1'b1;
            end
         end else if (ws) begin
            if (open_ff != CHAR_NUL) begin
               main_has    = 1'b1;
               main_rsp    = make_rsp(KIND_BYTE, in_byte, ERR_NONE, '0);
               nonempty_in = 1'b1;
            end else if (nonempty_ff) begin
               main_has    = 1'b1;
               main_rsp    = make_rsp(KIND_END, CHAR_NUL, ERR_NONE, '0);
               nonempty_in = 1'b0;
            end
         end else if (open_ff != CHAR_NUL && in_byte == open_ff) begin
            open_in     = CHAR_NUL;
            nonempty_in = 1'b0;
            if (end_of_string) begin
               main_has = 1'b1;
               main_rsp = make_rsp(KIND_END, CHAR_NUL, ERR_NONE, '0);
            end else begin
               pending_in = 1'b1;
            end
         end else if (quote_hit) begin
            if (open_ff != CHAR_NUL) begin
               main_has    = 1'b1;
               main_rsp    = make_rsp(KIND_BYTE, in_byte, ERR_NONE, '0);
               nonempty_in = 1'b1;
            end else if (nonempty_ff) begin
               main_has = 1'b1;
               main_rsp = make_rsp(KIND_ERROR, CHAR_NUL, ERR_STRAY_OPEN, pos_cur);
               error_in = 1'b1;
            end else begin
               open_in = in_byte;
            end
         end else begin
            main_has    = 1'b1;
            main_rsp    = make_rsp(KIND_BYTE, in_byte, ERR_NONE, '0);
            nonempty_in = 1'b1;
         end

         if (end_of_string && !error_in) begin
            if (open_in != CHAR_NUL) begin
               end_has = 1'b1;
               end_rsp = make_rsp(KIND_ERROR, CHAR_NUL, ERR_LEFT_OPEN, pos_cur);
            end else if (nonempty_in) begin
               end_has = 1'b1;
               end_rsp = make_rsp(KIND_END, CHAR_NUL, ERR_NONE, '0);
            end
         end
      end

      if (end_of_string) begin
         open_in     = CHAR_NUL;
         nonempty_in = 1'b0;
         pending_in  = 1'b0;
         error_in    = 1'b0;
         index_in    = '0;
      end
   end

   always_comb begin
      push        = '0;
      push.count  = accept ? (2'(main_has) + 2'(end_has)) : 2'd0;
      push.first  = main_has ? main_rsp : end_rsp;
      push.second = end_rsp;
      if (main_has && end_has) begin
         push.second.last_of_run = 1'b1;
      end else begin
         push.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= CHAR_NUL;
         nonempty_ff <= 1'b0;
         pending_ff  <= 1'b0;
         error_ff    <= 1'b0;
         index_ff    <= '0;
      end else if (accept) begin
         open_ff     <= open_in;
         nonempty_ff <= nonempty_in;
         pending_ff  <= pending_in;
         error_ff    <= error_in;
         index_ff    <= index_in;
      end
   end

endmodule

[rtl/core/gas_rsp_fifo.sv]
// Result queue: up to two in per request, one out per cycle while rsp_ready is set.
module gas_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  gas_pkg::push_type push,
   output logic              push_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gas_pkg::rsp_type  rsp_data
);
   import gas_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   rsp_type            entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   always_comb begin
      pop      = (count_ff != '0) && rsp_ready;
      head_in  = head_ff + PTR_W'(pop);
      tail_in  = tail_ff + PTR_W'(push.count);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_ff + PTR_W'(1)] <= push.second;
      end
   end

   assign push_ready = count_ff <= CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = entry_ff[head_ff];

endmodule

[rtl/core/grouped_argument_splitter_core.sv]
// Top level of the quoted-argument splitter.
//
//   channel  dir  handshake            payload
//   req_if   in   valid/ready          in_byte, end_of_string
//   rsp_if   out  valid/ready          kind, out_byte, error_code, error_position, last_of_run
//   csr      in   csr_we (no ready)    csr_index, csr_wdata
//
// One request per cycle while req_if.ready is high; the tokenizer state updates in the cycle
// it is accepted. A request yields zero, one or two results, queued four deep and sent one
// per cycle while rsp_if.ready is high, so a steady run of two-result requests is throttled.
// Results are registered in the queue before they reach rsp_if. req_if.ready drops when fewer
// than two queue slots are free. Synchronous reset restores the default quote characters.
module grouped_argument_splitter_core #(
   parameter int NUM_QUOTE_SLOTS = gas_pkg::NUM_QUOTE_SLOTS_DEF,
   parameter int INDEX_WIDTH     = gas_pkg::INDEX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   gas_req_if.sink                         req_if,
   gas_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [gas_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gas_pkg::BYTE_W-1:0]      csr_wdata
);
   import gas_pkg::*;

   logic [NUM_QUOTE_SLOTS-1:0][BYTE_W-1:0] quote_chars;
   logic                                   accept;
   logic                                   push_ready;
   push_type                               push;
   rsp_type                                rsp_data;

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && push_ready;

   gas_csr #(
      .NUM_QUOTE_SLOTS(NUM_QUOTE_SLOTS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .quote_chars(quote_chars)
   );

   gas_step #(
      .NUM_QUOTE_SLOTS(NUM_QUOTE_SLOTS),
      .INDEX_WIDTH    (INDEX_WIDTH)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_if.in_byte),
      .end_of_string(req_if.end_of_string),
      .quote_chars  (quote_chars),
      .push         (push)
   );

   gas_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ready(push_ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.kind           = rsp_data.kind;
   assign rsp_if.out_byte       = rsp_data.out_byte;
   assign rsp_if.error_code     = rsp_data.error_code;
   assign rsp_if.error_position = rsp_data.error_position;
   assign rsp_if.last_of_run    = rsp_data.last_of_run;

endmodule

[rtl/core/gas_checker.sv]
// Port-level checks of the argument splitter, bound to the top level.
`include "grouped_argument_splitter_core_macros.svh"

module gas_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input gas_pkg::kind_type          rsp_kind,
   input logic [gas_pkg::BYTE_W-1:0] rsp_out_byte,
   input gas_pkg::err_type           rsp_error_code,
   input logic [gas_pkg::POS_W-1:0]  rsp_error_position,
   input logic                       rsp_last_of_run
);
   import gas_pkg::*;

   `GAS_ASSERT_IMPLY(a_byte_clean, clock, reset, rsp_valid && rsp_kind == KIND_BYTE, rsp_error_code == ERR_NONE && rsp_error_position == '0)
   `GAS_ASSERT_IMPLY(a_end_clean, clock, reset, rsp_valid && rsp_kind == KIND_END, rsp_out_byte == CHAR_NUL && rsp_error_code == ERR_NONE && rsp_error_position == '0)
   `GAS_ASSERT_IMPLY(a_error_last, clock, reset, rsp_valid && rsp_kind == KIND_ERROR, rsp_error_code != ERR_NONE && rsp_out_byte == CHAR_NUL && rsp_last_of_run)
   `GAS_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid, rsp_kind == KIND_BYTE || rsp_kind == KIND_END || rsp_kind == KIND_ERROR)
   `GAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind grouped_argument_splitter_core gas_checker u_gas_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_kind          (rsp_if.kind),
   .rsp_out_byte      (rsp_if.out_byte),
   .rsp_error_code    (rsp_if.error_code),
   .rsp_error_position(rsp_if.error_position),
   .rsp_last_of_run   (rsp_if.last_of_run)
);
